[rtl/core/cmre_pkg.sv]
`default_nettype none

package cmre_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int HW_BITS = 6;
    localparam logic [HW_BITS-1:0] HW_RESET = 6'd8;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

[rtl/core/cmre_in_if.sv]
`default_nettype none

interface cmre_in_if;

    logic valid;
    logic ready;
    logic signed [cmre_pkg::SAMPLE_BITS-1:0] sample;
    logic last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);

endinterface

`default_nettype wire

[rtl/core/cmre_out_if.sv]
`default_nettype none

interface cmre_out_if;

    logic valid;
    logic ready;
    logic [cmre_pkg::SAMPLE_BITS-1:0] rms;
    logic last_res;

    modport source (output valid, output rms, output last_res, input ready);
    modport sink (input valid, input rms, input last_res, output ready);

endinterface

`default_nettype wire

[rtl/core/cmre_div.sv]
`default_nettype none

module cmre_div #(
    parameter int DW = 37,
    parameter int VW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [VW-1:0]        divisor,
    output cmre_pkg::unit_stat_t stat,
    output logic [DW-1:0]        quot
);

    localparam int CTW = $clog2(DW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  acc_reg, acc_next;
    logic [VW-1:0]  rem_reg, rem_next;
    logic [VW-1:0]  dsr_reg, dsr_next;
    logic [VW:0]    rem_sh;
    logic [VW:0]    rem_sub;
    logic           fits;

    assign rem_sh  = {rem_reg, acc_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CTW'(DW);
            acc_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[DW-2:0], fits};
            rem_next = fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            cnt_next = cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = acc_reg;

endmodule

`default_nettype wire

[rtl/core/cmre_sqrt.sv]
`default_nettype none

module cmre_sqrt #(
    parameter int RW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*RW-1:0]      radicand,
    output cmre_pkg::unit_stat_t stat,
    output logic [RW-1:0]        root
);

    localparam int CTW = $clog2(RW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CTW-1:0]  cnt_reg, cnt_next;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW:0]     rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   rem_sub;
    logic            fits;

    assign rem_sh  = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign fits    = (rem_sh >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CTW'(RW);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[2*RW-3:0], 2'b00};
            rem_next  = fits ? rem_sub[RW:0] : rem_sh[RW:0];
            root_next = {root_reg[RW-2:0], fits};
            cnt_next  = cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

[rtl/core/centered_moving_rms_envelope_unit.sv]
// Channel      Port                 Direction  Payload
// samples      samples.valid/ready  in         sample (signed Q1.15), last
// envelope     envelope.valid/ready out        rms (unsigned Q1.15), last_res
// config       cfg_wr_en            in         cfg_wr_data = half_width
//
// For each result the block reads the n samples of the clipped window, then runs the
// bit-serial divider (37 steps) and square root (16 steps) one after the other.
// Each item takes its request and, after its results, a check that nothing more is owed;
// an item that releases no result passes through only the request and the check.
// Reset clears the control state and sets half_width to 8; the delay memory
// is not cleared. A stalled envelope request holds the block before its next
// result, while an earlier result waits in the output register.
`default_nettype none

module centered_moving_rms_envelope_unit #(
    parameter int HALF_MAX = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cmre_pkg::HW_BITS-1:0]    cfg_wr_data,
    cmre_in_if.sink                         samples,
    cmre_out_if.source                      envelope
);

    localparam int SB    = cmre_pkg::SAMPLE_BITS;
    localparam int AW    = $clog2(2 * HALF_MAX);
    localparam int DEPTH = 1 << AW;
    localparam int CW    = AW + 1;
    localparam int SQW   = 2 * SB - 1;
    localparam int SW    = SQW + AW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [cmre_pkg::HW_BITS-1:0] half_width_reg;

    logic [SB-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] newest_addr;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] seen_reg, seen_next;
    logic [CW-1:0] off_reg, off_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          dzero_reg, dzero_next;
    logic          issue_reg, issue_next;
    logic          v1_reg, v2_reg;

    logic [SB-1:0]   rd_reg;
    logic [SB-1:0]   mag;
    logic [2*SB-1:0] prod;
    logic [SQW-1:0]  sq_reg;
    logic [SW-1:0]   sum_reg, sum_next;

    logic [CW-1:0] h_eff;
    logic [CW-1:0] thr;
    logic [CW-1:0] lo_c;
    logic [CW-1:0] hi_raw;
    logic [CW-1:0] hi_c;
    logic [CW-1:0] cnt_c;

    logic                 in_acc;
    logic                 out_load;
    logic                 div_start;
    logic                 sqrt_start;
    cmre_pkg::unit_stat_t div_stat;
    cmre_pkg::unit_stat_t sqrt_stat;
    logic [SW-1:0]        quot;
    logic [SB-1:0]        root;

    logic          out_valid_reg, out_valid_next;
    logic [SB-1:0] rms_reg;
    logic          last_res_reg;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_acc        = samples.valid && samples.ready;

    always_comb
    begin
        if (int'(half_width_reg) > HALF_MAX)
        begin
            h_eff = CW'(HALF_MAX);
        end
        else
        begin
            h_eff = CW'(half_width_reg);
        end
    end

    assign thr = ((h_eff == '0) || last_reg) ? CW'(1) : h_eff;

    // Window of the oldest owed result, as distances behind the newest sample.
    always_comb
    begin
        if (h_eff == '0)
        begin
            lo_c   = off_reg - CW'(1);
            hi_raw = off_reg - CW'(1);
        end
        else
        begin
            lo_c   = (off_reg >= h_eff) ? (off_reg - h_eff) : '0;
            hi_raw = off_reg - CW'(1) + h_eff;
        end
        hi_c  = (hi_raw > (seen_reg - CW'(1))) ? (seen_reg - CW'(1)) : hi_raw;
        cnt_c = hi_c - lo_c + CW'(1);
    end

    assign newest_addr = wp_reg - AW'(1);
    assign rd_addr     = newest_addr - k_reg[AW-1:0];
    assign mag         = rd_reg[SB-1] ? (~rd_reg + SB'(1)) : rd_reg;
    assign prod        = mag * mag;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        off_next   = off_reg;
        k_next     = k_reg;
        hi_next    = hi_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        dzero_next = dzero_reg;
        issue_next = issue_reg;
        sum_next   = v2_reg ? (sum_reg + SW'(sq_reg)) : sum_reg;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    last_next  = samples.last;
                    seen_next  = (seen_reg == CW'(DEPTH)) ? seen_reg : (seen_reg + CW'(1));
                    off_next   = off_reg + CW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (off_reg >= thr)
                begin
                    k_next     = lo_c;
                    hi_next    = hi_c;
                    cnt_next   = cnt_c;
                    dzero_next = (off_reg == CW'(1));
                    issue_next = 1'b1;
                    sum_next   = '0;
                    state_next = ST_ACC;
                end
                else
                begin
                    if (last_reg)
                    begin
                        seen_next = '0;
                        off_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                if (issue_reg)
                begin
                    k_next = k_reg + CW'(1);
                    if (k_reg == hi_reg)
                    begin
                        issue_next = 1'b0;
                    end
                end
                else if (!v1_reg && !v2_reg && !div_stat.busy)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || envelope.ready)
                begin
                    out_load   = 1'b1;
                    off_next   = off_reg - CW'(1);
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (envelope.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            half_width_reg <= cmre_pkg::HW_RESET;
            wp_reg         <= '0;
            seen_reg       <= '0;
            off_reg        <= '0;
            k_reg          <= '0;
            hi_reg         <= '0;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            dzero_reg      <= 1'b0;
            issue_reg      <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                half_width_reg <= cfg_wr_data;
            end
            if (in_acc)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            seen_reg      <= seen_next;
            off_reg       <= off_next;
            k_reg         <= k_next;
            hi_reg        <= hi_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            dzero_reg     <= dzero_next;
            issue_reg     <= issue_next;
            v1_reg        <= (state_reg == ST_ACC) && issue_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mem[wp_reg] <= samples.sample;
        end
        rd_reg  <= mem[rd_addr];
        sq_reg  <= prod[SQW-1:0];
        sum_reg <= sum_next;
        if (out_load)
        begin
            rms_reg      <= root;
            last_res_reg <= last_reg && dzero_reg;
        end
    end

    cmre_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .stat     (div_stat),
        .quot     (quot)
    );

    cmre_sqrt #(
        .RW (SB)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({1'b0, quot[SQW-1:0]}),
        .stat     (sqrt_stat),
        .root     (root)
    );

    assign envelope.valid    = out_valid_reg;
    assign envelope.rms      = rms_reg;
    assign envelope.last_res = last_res_reg;

endmodule

`default_nettype wire

[rtl/core/cmre_checker.sv]
`default_nettype none

module cmre_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_rms,
    input wire logic        out_last_res
);

    // The block works on one sample request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("sample request taken while a previous one is in work");

    // A result passes through the divider and square root, so none appears right after a sample request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after a sample request");

    // The square root of a Q1.30 mean never exceeds one in Q1.15.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rms <= 16'd32768)
    else $error("envelope value out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rms) && $stable(out_last_res))
    else $error("stalled envelope request changed");

endmodule

bind centered_moving_rms_envelope_unit cmre_checker u_cmre_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .out_valid    (envelope.valid),
    .out_ready    (envelope.ready),
    .out_rms      (envelope.rms),
    .out_last_res (envelope.last_res)
);

`default_nettype wire
